### rtl/core/carc_pkg.sv
package carc_pkg;

	// Field and port widths
	localparam int VAL_W      = 24;
	localparam int DT_W       = 16;
	localparam int AXIS_IN_W  = 2;
	localparam int IN_DATA_W  = 3 * VAL_W + DT_W;
	localparam int LIM_W      = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_REGS   = 3;
	localparam int NUM_AXES_DEF = 3;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Gains, Q4.12
	localparam logic signed [MUL_B_W-1:0] K_THETA = 17'sd28672;
	localparam logic signed [MUL_B_W-1:0] K_P     = 17'sd5325;
	localparam logic signed [MUL_B_W-1:0] K_I     = 17'sd2662;
	localparam logic signed [MUL_B_W-1:0] K_D     = 17'sd4915;
	localparam logic signed [MUL_B_W-1:0] K_LEAK  = 17'sd819;

	// Bounds, Q15.8
	localparam int RATE_MAX  = 64000;
	localparam int INTEG_MAX = 64000;
	localparam int DIST_MAX  = 51200;
	localparam int DRIVE_MAX = 76800;

	// Angle wrap
	localparam int TURN       = 92160;
	localparam int HALF_TURN  = 46080;
	localparam int WRAP_STEPS = 9;
	localparam int TURN_BIAS  = TURN << (WRAP_STEPS - 1);

endpackage

### rtl/core/carc_mul.sv
module carc_mul (
	input  logic                                 clk,
	input  logic signed [carc_pkg::MUL_A_W-1:0]  op_a,
	input  logic signed [carc_pkg::MUL_B_W-1:0]  op_b,
	output logic signed [carc_pkg::MUL_P_W-1:0]  prod
);
	import carc_pkg::*;

	logic signed [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
	end

	assign prod = prod_q;

endmodule

### rtl/core/cascade_angle_rate_controller_core.sv
// Channel  Dir   Handshake              Payload
// s_       in    s_tvalid / s_tready    s_tdata: angle_measured, rate_measured, angle_target,
//                                       time_step; s_tuser: axis_index
// m_       out   m_tvalid / m_tready    m_tdata: position_command; m_tuser: rejected
// cfg_     in    cfg_valid / cfg_ready  cfg_index, cfg_data (axis limits)
//
// A valid step runs a nine-step turn reduction in one subtractor, then ten products
// through the single registered 25x17 multiplier.
// A rejected step skips the datapath and goes from accept straight to the final state.
// s_tready is high only while no step is in work; a new step waits until the last one is done.
// A result waits in the output register while the next step is computed; the step
// holds in its last state until that register is free. Config is always ready.
// arst_n clears limits, per-axis integral, estimate, command and seed flags.
module cascade_angle_rate_controller_core #(
	parameter int NUM_AXES = carc_pkg::NUM_AXES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [23:0] angle_measured, [47:24] rate_measured, [71:48] angle_target, [87:72] time_step
	input  logic [carc_pkg::IN_DATA_W-1:0]     s_tdata,
	// [1:0] axis_index
	input  logic [carc_pkg::AXIS_IN_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [23:0] position_command
	output logic [carc_pkg::VAL_W-1:0]         m_tdata,
	// [0] rejected
	output logic [0:0]                         m_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [carc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [carc_pkg::LIM_W-1:0]         cfg_data
);
	import carc_pkg::*;

	localparam int AXIS_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int R_W     = 26;
	localparam int K_W     = $clog2(WRAP_STEPS);
	localparam int E_W     = 17;
	localparam int EW_W    = 25;
	localparam int X_W     = 38;
	localparam int INTEG_W = 18;
	localparam int DIST_W  = 17;
	localparam int CMD_W   = 18;
	localparam int DRV_W   = 18;
	localparam int QH_W    = 18;
	localparam int STEP_W  = 26;
	localparam int SLEW_W  = 16;

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] S_IDLE = 5'd0;
	localparam logic [ST_W-1:0] S_WRAP = 5'd1;
	localparam logic [ST_W-1:0] S_E    = 5'd2;
	localparam logic [ST_W-1:0] S_M0   = 5'd3;
	localparam logic [ST_W-1:0] S_M1   = 5'd4;
	localparam logic [ST_W-1:0] S_M2   = 5'd5;
	localparam logic [ST_W-1:0] S_M3   = 5'd6;
	localparam logic [ST_W-1:0] S_M4   = 5'd7;
	localparam logic [ST_W-1:0] S_M5   = 5'd8;
	localparam logic [ST_W-1:0] S_M6   = 5'd9;
	localparam logic [ST_W-1:0] S_M7   = 5'd10;
	localparam logic [ST_W-1:0] S_M8   = 5'd11;
	localparam logic [ST_W-1:0] S_M9   = 5'd12;
	localparam logic [ST_W-1:0] S_M10  = 5'd13;
	localparam logic [ST_W-1:0] S_DONE = 5'd14;

	function automatic logic signed [31:0] clamp32(
		input logic signed [31:0] x,
		input logic signed [31:0] lo,
		input logic signed [31:0] hi
	);
		logic signed [31:0] y;
		if (x < lo) begin
			y = lo;
		end else if (x > hi) begin
			y = hi;
		end else begin
			y = x;
		end
		return y;
	endfunction

	// Control and per-axis state
	logic [ST_W-1:0]                 state_q;
	logic                            mv_q;
	logic [LIM_W-1:0]                lim_q [NUM_AXES];
	logic signed [INTEG_W-1:0]       integ_q [NUM_AXES];
	logic signed [DIST_W-1:0]        dist_q [NUM_AXES];
	logic signed [CMD_W-1:0]         cmd_q [NUM_AXES];
	logic [NUM_AXES-1:0]             seeded_q;

	// Working registers of one step
	logic [AXIS_W-1:0]               a_q;
	logic                            rej_q;
	logic signed [VAL_W-1:0]         th_q;
	logic signed [VAL_W-1:0]         om_q;
	logic [DT_W-1:0]                 dt_q;
	logic signed [CMD_W-1:0]         pmin_q;
	logic signed [CMD_W-1:0]         pmax_q;
	logic [SLEW_W-1:0]               slew_q;
	logic [R_W-1:0]                  r_q;
	logic [K_W-1:0]                  k_q;
	logic signed [E_W-1:0]           e_q;
	logic signed [CMD_W-1:0]         prev_q;
	logic signed [EW_W-1:0]          ew_q;
	logic signed [X_W-1:0]           x_q;
	logic signed [INTEG_W-1:0]       in_q;
	logic [QH_W-1:0]                 qh_q;
	logic signed [DIST_W-1:0]        dn_q;
	logic signed [DRV_W-1:0]         u_q;
	logic signed [STEP_W-1:0]        step_q;
	logic signed [CMD_W-1:0]         cmdn_q;
	logic [VAL_W-1:0]                mdata_q;
	logic                            mrej_q;

	// Input fields
	logic signed [VAL_W-1:0]         th_in;
	logic signed [VAL_W-1:0]         om_in;
	logic signed [VAL_W-1:0]         ref_in;
	logic [DT_W-1:0]                 dt_in;
	logic                            axis_ok;
	logic                            rej_in;
	logic                            s_acc;
	logic                            out_free;
	logic [LIM_W-1:0]                lim_sel;

	// Shared multiplier
	logic signed [MUL_A_W-1:0]       mul_a;
	logic signed [MUL_B_W-1:0]       mul_b;
	logic signed [MUL_P_W-1:0]       mul_p;
	logic signed [MUL_B_W-1:0]       dt_s;

	// Datapath values
	logic signed [INTEG_W-1:0]       icur;
	logic signed [DIST_W-1:0]        dcur;
	logic [R_W-1:0]                  turn_k;
	logic signed [31:0]              r_n;
	logic signed [31:0]              re;
	logic signed [31:0]              e_n;
	logic signed [31:0]              seed_n;
	logic signed [31:0]              p_r8;
	logic signed [31:0]              p_r12;
	logic signed [31:0]              p_r16;
	logic signed [31:0]              wref;
	logic signed [31:0]              in_n;
	logic signed [31:0]              qh_n;
	logic signed [31:0]              dn_n;
	logic signed [X_W-1:0]           drv_sum;
	logic signed [31:0]              u_n;
	logic signed [31:0]              pos1;
	logic signed [31:0]              pos2;
	logic signed [31:0]              pos3;

	assign th_in  = s_tdata[VAL_W-1:0];
	assign om_in  = s_tdata[2*VAL_W-1:VAL_W];
	assign ref_in = s_tdata[3*VAL_W-1:2*VAL_W];
	assign dt_in  = s_tdata[IN_DATA_W-1:3*VAL_W];

	assign axis_ok  = int'(s_tuser) < NUM_AXES;
	assign rej_in   = !axis_ok || (dt_in == '0);
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !mv_q || m_tready;
	assign lim_sel  = axis_ok ? lim_q[AXIS_W'(s_tuser)] : '0;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = mv_q;
	assign m_tdata   = mdata_q;
	assign m_tuser   = mrej_q;

	assign dt_s = signed'({1'b0, dt_q});
	assign icur = integ_q[a_q];
	assign dcur = dist_q[a_q];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M0: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = K_THETA;
			end
			S_M1: begin
				mul_a = MUL_A_W'(dcur);
				mul_b = K_LEAK;
			end
			S_M2: begin
				mul_a = ew_q;
				mul_b = K_D;
			end
			S_M3: begin
				mul_a = ew_q;
				mul_b = dt_s;
			end
			S_M4: begin
				// low 20 bits of the observer term, unsigned
				mul_a = signed'(MUL_A_W'(x_q[19:0]));
				mul_b = dt_s;
			end
			S_M5: begin
				mul_a = MUL_A_W'(x_q >>> 20);
				mul_b = dt_s;
			end
			S_M6: begin
				mul_a = ew_q;
				mul_b = K_P;
			end
			S_M7: begin
				mul_a = MUL_A_W'(in_q);
				mul_b = K_I;
			end
			S_M8: begin
				mul_a = signed'(MUL_A_W'(slew_q));
				mul_b = dt_s;
			end
			S_M9: begin
				mul_a = MUL_A_W'(u_q);
				mul_b = dt_s;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	carc_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_p)
	);

	always_comb begin
		r_n    = 32'(ref_in) - 32'(th_in) + 32'(TURN_BIAS);
		turn_k = R_W'(TURN) << k_q;
		re     = signed'(32'(r_q));
		e_n    = (re >= HALF_TURN) ? re - TURN : re;
		seed_n = clamp32(32'(th_q), 32'(pmin_q), 32'(pmax_q));

		// round to nearest, ties up
		p_r8  = 32'((mul_p + MUL_P_W'(128)) >>> 8);
		p_r12 = 32'((mul_p + MUL_P_W'(2048)) >>> 12);
		p_r16 = 32'((mul_p + MUL_P_W'(32768)) >>> 16);

		wref = clamp32(p_r12, -RATE_MAX, RATE_MAX);
		in_n = clamp32(32'(icur) + p_r16, -INTEG_MAX, INTEG_MAX);
		// low partial product carries the rounding offset of the 28-bit rescale
		qh_n = 32'((mul_p + MUL_P_W'(134217728)) >>> 20);
		dn_n = clamp32(32'(dcur) + 32'((mul_p + MUL_P_W'(signed'({1'b0, qh_q}))) >>> 8),
			-DIST_MAX, DIST_MAX);

		drv_sum = x_q + X_W'(mul_p);
		u_n     = clamp32(32'((drv_sum + X_W'(2048)) >>> 12) - 32'(dn_q),
			-DRIVE_MAX, DRIVE_MAX);

		pos1 = 32'(prev_q) + p_r16;
		pos2 = clamp32(pos1, 32'(prev_q) - 32'(step_q), 32'(prev_q) + 32'(step_q));
		pos3 = clamp32(pos2, 32'(pmin_q), 32'(pmax_q));
	end

	// Sequencer, output register and per-axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mv_q     <= 1'b0;
			seeded_q <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				lim_q[i]   <= '0;
				integ_q[i] <= '0;
				dist_q[i]  <= '0;
				cmd_q[i]   <= '0;
			end
		end else begin
			if (cfg_valid && (int'(cfg_index) < CFG_REGS) && (int'(cfg_index) < NUM_AXES)) begin
				lim_q[AXIS_W'(cfg_index)] <= cfg_data;
			end

			// the final state reloads the output register itself
			if (mv_q && m_tready && (state_q != S_DONE)) begin
				mv_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						state_q <= rej_in ? S_DONE : S_WRAP;
					end
				end
				S_WRAP: begin
					if (k_q == '0) begin
						state_q <= S_E;
					end
				end
				S_E:   state_q <= S_M0;
				S_M0:  state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_M4;
				S_M4:  state_q <= S_M5;
				S_M5:  state_q <= S_M6;
				S_M6:  state_q <= S_M7;
				S_M7:  state_q <= S_M8;
				S_M8:  state_q <= S_M9;
				S_M9:  state_q <= S_M10;
				S_M10: state_q <= S_DONE;
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						mv_q    <= 1'b1;
						state_q <= S_IDLE;
						if (!rej_q) begin
							integ_q[a_q]  <= in_q;
							dist_q[a_q]   <= dn_q;
							cmd_q[a_q]    <= cmdn_q;
							seeded_q[a_q] <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					a_q    <= AXIS_W'(s_tuser);
					rej_q  <= rej_in;
					th_q   <= th_in;
					om_q   <= om_in;
					dt_q   <= dt_in;
					pmin_q <= signed'({lim_sel[15:0], 2'b00});
					pmax_q <= signed'({lim_sel[31:16], 2'b00});
					slew_q <= lim_sel[47:32];
					r_q    <= R_W'(r_n);
					k_q    <= K_W'(WRAP_STEPS - 1);
				end
			end
			S_WRAP: begin
				// strip one shifted turn per cycle
				if (r_q >= turn_k) begin
					r_q <= r_q - turn_k;
				end
				if (k_q != '0) begin
					k_q <= k_q - 1'b1;
				end
			end
			S_E: begin
				e_q    <= E_W'(e_n);
				prev_q <= seeded_q[a_q] ? cmd_q[a_q] : CMD_W'(seed_n);
			end
			S_M1: ew_q   <= EW_W'(wref - 32'(om_q));
			S_M2: x_q    <= -X_W'(mul_p);
			S_M3: x_q    <= x_q + X_W'(mul_p);
			S_M4: in_q   <= INTEG_W'(in_n);
			S_M5: qh_q   <= QH_W'(qh_n);
			S_M6: dn_q   <= DIST_W'(dn_n);
			S_M7: x_q    <= X_W'(mul_p);
			S_M8: u_q    <= DRV_W'(u_n);
			S_M9: step_q <= STEP_W'(p_r8);
			S_M10: cmdn_q <= CMD_W'(pos3);
			S_DONE: begin
				if (out_free) begin
					mdata_q <= rej_q ? th_q : VAL_W'(cmdn_q);
					mrej_q  <= rej_q;
				end
			end
			default: ;
		endcase
	end

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result raised outside the final state");

	a_wrap_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_E) |-> (r_q < R_W'(TURN)))
		else $error("turn reduction left a residue of a full turn or more");

	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M9) |-> ((32'(u_q) <= DRIVE_MAX) && (32'(u_q) >= -DRIVE_MAX)))
		else $error("drive outside its saturation bound");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input ready while a step is in work");

endmodule

### sim/carc_command_check.sv
`timescale 1ns / 100ps

module carc_command_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// [23:0] angle_measured, [47:24] rate_measured, [71:48] angle_target, [87:72] time_step
	input  logic [carc_pkg::IN_DATA_W-1:0] s_tdata,
	// [1:0] axis_index
	input  logic [carc_pkg::AXIS_IN_W-1:0] s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// [23:0] position_command
	input  logic [carc_pkg::VAL_W-1:0]     m_tdata,
	// [0] rejected
	input  logic [0:0]                     m_tuser,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [carc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [carc_pkg::LIM_W-1:0]     cfg_data,
	output int                             fail_count,
	output int                             pending
);

	localparam int VW   = carc_pkg::VAL_W;
	localparam int AXES = 3;

	// Q4.12 gains and Q15.8 bounds of the control law
	localparam longint GAIN_ANGLE = 28672;
	localparam longint GAIN_PROP  = 5325;
	localparam longint GAIN_INT   = 2662;
	localparam longint GAIN_OBS   = 4915;
	localparam longint GAIN_LEAK  = 819;
	localparam longint RATE_LIM   = 64000;
	localparam longint INTEG_LIM  = 64000;
	localparam longint OBS_LIM    = 51200;
	localparam longint DRIVE_LIM  = 76800;
	localparam longint HALF_REV   = 46080;
	localparam longint FULL_REV   = 92160;

	typedef struct packed {
		logic signed [VW-1:0] position;
		logic                 rejected;
	} command_t;

	command_t                  command_q[$];
	logic [carc_pkg::LIM_W-1:0] axis_limits[AXES];
	longint                    rate_integ[AXES];
	longint                    dist_est[AXES];
	longint                    cmd_pos[AXES];
	bit                        axis_seeded[AXES];
	int                        mismatches = 0;
	int                        queued = 0;
	command_t                  want;

	assign fail_count = mismatches;
	assign pending    = queued;

	// round to nearest, ties toward plus infinity
	function automatic longint round_shift(input longint x, input int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	function automatic command_t advance_axis(input logic [1:0] axis,
			input logic signed [VW-1:0] th_in, input logic signed [VW-1:0] om_in,
			input logic signed [VW-1:0] tgt_in, input logic [15:0] dt_in);
		longint th, om, tgt, dt, pmin, pmax, slew;
		longint err, rate_tgt, rate_err, drive, prev, pos, step;
		int a;
		command_t r;
		th = th_in;
		om = om_in;
		tgt = tgt_in;
		dt = dt_in;
		if (axis >= AXES || dt == 0) begin
			r.position = th_in;
			r.rejected = 1'b1;
			return r;
		end
		a = axis;
		pmin = longint'($signed(axis_limits[a][15:0])) * 4;
		pmax = longint'($signed(axis_limits[a][31:16])) * 4;
		slew = axis_limits[a][47:32];
		if (!axis_seeded[a]) begin
			axis_seeded[a] = 1'b1;
			cmd_pos[a] = clip(th, pmin, pmax);
		end
		// wrap into [-180, 180)
		err = (tgt - th) % FULL_REV;
		if (err < 0)
			err += FULL_REV;
		if (err >= HALF_REV)
			err -= FULL_REV;
		rate_tgt = clip(round_shift(GAIN_ANGLE * err, 12), -RATE_LIM, RATE_LIM);
		rate_err = rate_tgt - om;
		rate_integ[a] = clip(rate_integ[a] + round_shift(rate_err * dt, 16),
			-INTEG_LIM, INTEG_LIM);
		dist_est[a] = clip(dist_est[a] +
			round_shift((GAIN_OBS * rate_err - GAIN_LEAK * dist_est[a]) * dt, 28),
			-OBS_LIM, OBS_LIM);
		drive = round_shift(GAIN_PROP * rate_err + GAIN_INT * rate_integ[a], 12) - dist_est[a];
		drive = clip(drive, -DRIVE_LIM, DRIVE_LIM);
		prev = cmd_pos[a];
		pos = prev + round_shift(drive * dt, 16);
		step = round_shift(slew * dt, 8);
		pos = clip(pos, prev - step, prev + step);
		pos = clip(pos, pmin, pmax);
		cmd_pos[a] = pos;
		r.position = pos[VW-1:0];
		r.rejected = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q.delete();
			for (int i = 0; i < AXES; i++) begin
				axis_limits[i] = '0;
				rate_integ[i] = 0;
				dist_est[i] = 0;
				cmd_pos[i] = 0;
				axis_seeded[i] = 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < AXES)
				axis_limits[cfg_index] = cfg_data;
			if (m_tvalid && m_tready) begin
				if (command_q.size() == 0) begin
					$error("unexpected result beat: position_command %0d rejected %0b",
						$signed(m_tdata), m_tuser);
					mismatches++;
				end else begin
					want = command_q.pop_front();
					if (m_tdata !== want.position) begin
						$error("position_command expected %0d actual %0d",
							want.position, $signed(m_tdata));
						mismatches++;
					end
					if (m_tuser[0] !== want.rejected) begin
						$error("rejected expected %0b actual %0b", want.rejected, m_tuser[0]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				command_q.push_back(advance_axis(s_tuser, s_tdata[VW-1:0],
					s_tdata[2*VW-1:VW], s_tdata[3*VW-1:2*VW],
					s_tdata[carc_pkg::IN_DATA_W-1:3*VW]));
		end
		queued = command_q.size();
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SEGMENTS      = 6;
	localparam int SEG_ITEMS     = 238;
	localparam logic [1:0] AXIS_BAD   = 2'd3;
	localparam logic [1:0] REG_AXIS0  = 2'd0;
	localparam logic [1:0] REG_AXIS1  = 2'd1;
	localparam logic [1:0] REG_AXIS2  = 2'd2;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [carc_pkg::IN_DATA_W-1:0] s_tdata;
	logic [carc_pkg::AXIS_IN_W-1:0] s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [carc_pkg::VAL_W-1:0]     m_tdata;
	logic [0:0]                     m_tuser;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [carc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [carc_pkg::LIM_W-1:0]     cfg_data;
	int                             fail_count;
	int                             pending;
	int                             cycles = 0;
	int                             tx_idle = 30;
	int                             rx_idle = 58;

	always #5 clk = ~clk;

	cascade_angle_rate_controller_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	carc_command_check command_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= (rx_idle == 0) || ($urandom_range(99) >= rx_idle);

	function automatic logic [47:0] pack_limits(input int lo, input int hi, input int slew);
		return {slew[15:0], hi[15:0], lo[15:0]};
	endfunction

	function automatic logic [47:0] random_limits();
		if ($urandom_range(99) < 60)
			return pack_limits(-int'($urandom_range(0, 32768)), $urandom_range(0, 32767),
				($urandom_range(1) != 0) ? $urandom_range(0, 2000) : $urandom_range(0, 65535));
		return 48'({$urandom, $urandom});
	endfunction

	task automatic send_step(input logic [1:0] axis, input int th, input int om,
			input int tgt, input int dt);
		@(negedge clk);
		while (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dt[15:0], tgt[23:0], om[23:0], th[23:0]};
		s_tuser <= axis;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid and hold until every result beat has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [47:0] l0, input logic [47:0] l1,
			input logic [47:0] l2);
		drain();
		write_reg(REG_AXIS0, l0);
		write_reg(REG_AXIS1, l1);
		write_reg(REG_AXIS2, l2);
		write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_step();
		logic [1:0] axis;
		int pick, dt, th, om, tgt;
		axis = ($urandom_range(99) < 5) ? AXIS_BAD : 2'($urandom_range(2));
		pick = $urandom_range(99);
		dt = (pick < 3) ? 0 : (pick < 70) ? $urandom_range(1, 1000) : $urandom_range(1, 65535);
		if ($urandom_range(99) < 75) begin
			th = int'($urandom_range(0, 204800)) - 102400;
			if ($urandom_range(2) == 0)
				tgt = int'($urandom_range(0, 204800)) - 102400;
			else
				tgt = th + int'($urandom_range(0, 40000)) - 20000;
			om = int'($urandom_range(0, 160000)) - 80000;
		end else begin
			th = $urandom;
			tgt = $urandom;
			om = $urandom;
		end
		send_step(axis, th, om, tgt, dt);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// rejections before anything is seeded, then a seed under reset limits
		send_step(AXIS_BAD, 8388607, 0, 0, 100);
		send_step(2'd1, -8388608, 8388607, 0, 0);
		send_step(2'd1, 1000, 0, 2000, 655);
		configure(pack_limits(-32768, 32767, 65535), pack_limits(-11520, 11520, 400),
			pack_limits(1000, -1000, 100));
		// seed beyond the maximum, full-scale fields and the longest step
		send_step(2'd0, 8388607, 8388607, -8388608, 65535);
		send_step(2'd0, -8388608, -8388608, 8388607, 65535);
		// error exactly at the wrap boundary and around it
		send_step(2'd0, 0, 0, 46080, 655);
		send_step(2'd0, 0, 0, -46080, 655);
		send_step(2'd0, 100, 0, 46179, 655);
		send_step(2'd0, -300000, 0, -300000 + 3 * 92160 + 5, 655);
		// inverted limits, shortest step
		send_step(2'd2, 0, 0, 2560, 1000);
		send_step(2'd2, 5000, -2000, 0, 1);
		send_step(2'd0, 256, 0, 512, 1);
		// drive integral and disturbance estimate into their clamps
		repeat (3)
			send_step(2'd1, 0, -8388608, 46079, 65535);
		send_step(AXIS_BAD, -8388608, 0, 0, 0);
		send_step(2'd2, 12345, 0, 0, 0);
		// zero slew with tight limits: only the final clamp moves the command
		configure(pack_limits(-320, 320, 0), pack_limits(-11520, 11520, 400),
			pack_limits(1000, -1000, 100));
		send_step(2'd0, 0, 0, 20000, 65535);
		send_step(2'd0, 0, 8388607, -20000, 65535);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: configure(pack_limits(-32768, 32767, 65535), random_limits(),
					pack_limits(-11520, 11520, 400));
				2: configure(pack_limits(-5760, 5760, 90), pack_limits(32767, -32768, 300),
					random_limits());
				3: configure(pack_limits(-2000, 2000, 0), random_limits(), random_limits());
				5: configure(pack_limits(-32768, 32767, 65535),
					pack_limits(-32768, 32767, 65535), pack_limits(-32768, 32767, 65535));
				default: configure(random_limits(), random_limits(), random_limits());
			endcase
			if (seg < 2) begin
				tx_idle = 30;
				rx_idle = 58;
			end else if (seg < 4) begin
				tx_idle = 58;
				rx_idle = 30;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			repeat (SEG_ITEMS)
				random_step();
		end

		drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
